// ----- rtl/core/i8ew_pkg.sv -----
package i8ew_pkg;

    localparam int MAX_OPERANDS_DEF = 4;
    localparam int QUEUE_DEPTH_DEF  = 2;
    localparam int NUM_MULT         = 4;

    localparam int VAL_W  = 8;
    localparam int PROD_W = 16;
    localparam int RUN_W  = 18;
    localparam int SHF_W  = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_COMBINE_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELU_ENABLE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_AMOUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MULT_0       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MULT_1       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MULT_2       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MULT_3       = 3'd6;

    typedef enum logic [1:0] {
        MODE_SUM = 2'd0,
        MODE_MAX = 2'd1,
        MODE_MIN = 2'd2
    } t_mode;

    typedef logic [NUM_MULT-1:0][VAL_W-1:0] t_mult_arr;

    // one classified operand on its way from front to back
    typedef struct packed {
        logic [PROD_W-1:0] prod;
        logic              first;
        logic              comb;
        logic              last;
        logic [1:0]        mode;
        logic              relu;
        logic [SHF_W-1:0]  shift;
    } t_entry;

endpackage

// ----- rtl/core/i8ew_front.sv -----
module i8ew_front
    import i8ew_pkg::*;
#(
    parameter int MAX_OPERANDS = MAX_OPERANDS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_ready,
    input  logic signed [VAL_W-1:0] i_operand_value,
    input  logic                    i_last_operand,
    input  logic [1:0]              i_mode,
    input  logic                    i_relu,
    input  logic [SHF_W-1:0]        i_shift,
    input  t_mult_arr               i_mult,
    output t_entry                  o_entry
);

    localparam int CNT_W = $clog2(MAX_OPERANDS + 1);

    logic [1:0]       r_sel;
    logic [1:0]       n_sel;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             accept;
    logic             comb;
    logic signed [VAL_W-1:0]  mult;
    logic signed [PROD_W-1:0] prod;

    assign accept = i_in_valid && i_in_ready;
    assign comb   = r_cnt < CNT_W'(MAX_OPERANDS);
    assign mult   = $signed(i_mult[r_sel]);
    assign prod   = i_operand_value * mult;

    always_comb begin
        o_entry.prod  = prod;
        o_entry.first = (r_cnt == '0);
        o_entry.comb  = comb;
        o_entry.last  = i_last_operand;
        o_entry.mode  = i_mode;
        o_entry.relu  = i_relu;
        o_entry.shift = i_shift;
    end

    always_comb begin
        n_sel = r_sel;
        n_cnt = r_cnt;
        if (accept) begin
            if (i_last_operand) begin
                n_sel = '0;
                n_cnt = '0;
            end else if (comb) begin
                n_cnt = r_cnt + CNT_W'(1);
                if (r_sel != 2'd3) begin
                    n_sel = r_sel + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel <= '0;
            r_cnt <= '0;
        end else begin
            r_sel <= n_sel;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ----- rtl/core/i8ew_queue.sv -----
module i8ew_queue
    import i8ew_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    output logic   o_ready,
    input  logic   i_pop,
    output logic   o_valid,
    output t_entry o_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        r = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
        return r;
    endfunction

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

// ----- rtl/core/i8ew_back.sv -----
module i8ew_back
    import i8ew_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  t_entry           i_entry,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [VAL_W-1:0] o_result_value
);

    localparam logic signed [RUN_W-1:0] RUN_MAX = {1'b0, {(RUN_W-1){1'b1}}};
    localparam logic signed [RUN_W-1:0] RUN_MIN = {1'b1, {(RUN_W-1){1'b0}}};

    logic signed [RUN_W-1:0] r_run;
    logic                    r_fin_valid;
    logic signed [RUN_W-1:0] r_fin_val;
    logic [SHF_W-1:0]        r_fin_shift;
    logic                    r_out_valid;
    logic [VAL_W-1:0]        r_out_val;

    logic signed [RUN_W-1:0] p_ext;
    logic signed [RUN_W:0]   sum_wide;
    logic signed [RUN_W-1:0] sum_sat;
    logic signed [RUN_W-1:0] val;
    logic signed [RUN_W-1:0] fin_in;
    logic                    out_free;
    logic                    fin_ready;

    // round half away from zero, then saturate to int8
    function automatic logic [VAL_W-1:0] requant(input logic signed [RUN_W-1:0] v,
                                                 input logic [SHF_W-1:0] s);
        logic             neg;
        logic [RUN_W-1:0] mag;
        logic [31:0]      half;
        logic [31:0]      rnd;
        logic [VAL_W-1:0] res;
        neg  = v[RUN_W-1];
        mag  = neg ? RUN_W'(-v) : RUN_W'(v);
        half = (s == '0) ? 32'd0 : (32'd1 << (s - SHF_W'(1)));
        rnd  = ({{(32-RUN_W){1'b0}}, mag} + half) >> s;
        if (neg) begin
            res = (rnd > 32'd128) ? 8'h80 : VAL_W'(-rnd);
        end else begin
            res = (rnd > 32'd127) ? 8'h7F : VAL_W'(rnd);
        end
        return res;
    endfunction

    assign out_free  = !r_out_valid || i_out_ready;
    assign fin_ready = !r_fin_valid || out_free;
    // a closing beat needs room in the rounding stage
    assign o_pop     = i_valid && (!i_entry.last || fin_ready);

    always_comb begin
        p_ext    = {{(RUN_W-PROD_W){i_entry.prod[PROD_W-1]}}, i_entry.prod};
        sum_wide = {r_run[RUN_W-1], r_run} + {p_ext[RUN_W-1], p_ext};
        if (sum_wide > $signed({RUN_MAX[RUN_W-1], RUN_MAX})) begin
            sum_sat = RUN_MAX;
        end else if (sum_wide < $signed({RUN_MIN[RUN_W-1], RUN_MIN})) begin
            sum_sat = RUN_MIN;
        end else begin
            sum_sat = sum_wide[RUN_W-1:0];
        end

        val = r_run;
        if (i_entry.comb) begin
            if (i_entry.first) begin
                val = p_ext;
            end else begin
                case (i_entry.mode)
                    MODE_MAX: val = (p_ext > r_run) ? p_ext : r_run;
                    MODE_MIN: val = (p_ext < r_run) ? p_ext : r_run;
                    default:  val = sum_sat;
                endcase
            end
        end

        fin_in = (i_entry.relu && val[RUN_W-1]) ? '0 : val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop && i_entry.last) begin
                r_fin_valid <= 1'b1;
            end else if (out_free) begin
                r_fin_valid <= 1'b0;
            end
            if (out_free) begin
                r_out_valid <= r_fin_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_run <= val;
        end
        if (o_pop && i_entry.last) begin
            r_fin_val   <= fin_in;
            r_fin_shift <= i_entry.shift;
        end
        if (out_free && r_fin_valid) begin
            r_out_val <= requant(r_fin_val, r_fin_shift);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_out_val;

endmodule

// ----- rtl/core/int8_eltwise_add_max_min_requant.sv -----
// int8 element-wise combine with requantization. Operand elements of one tensor
// position arrive one beat at a time in operand order; the beat with
// i_last_operand set closes the position and yields one o_result_value. Each
// element is scaled by the multiplier of its operand (mult_3 for the fourth and
// later ones), then summed (saturating to 18 bits), or reduced by maximum or
// minimum, under the mode in force when it arrives; elements past MAX_OPERANDS
// are dropped. ReLU, the rounding right shift and int8 saturation use the
// settings current at the closing beat. Throughput is one beat per cycle
// unless output back-pressure holds a closing beat: the front multiplies and
// classifies, a QUEUE_DEPTH entry queue decouples it from the back, whose
// accumulate/compare loop sets the rate.
module int8_eltwise_add_max_min_requant
    import i8ew_pkg::*;
#(
    parameter int MAX_OPERANDS = MAX_OPERANDS_DEF,
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic signed [VAL_W-1:0] i_operand_value,
    input  logic                    i_last_operand,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [VAL_W-1:0] o_result_value
);

    logic [1:0]       r_mode;
    logic             r_relu;
    logic [SHF_W-1:0] r_shift;
    t_mult_arr        r_mult;

    t_entry           front_entry;
    t_entry           back_entry;
    logic             q_ready;
    logic             q_valid;
    logic             q_pop;
    logic             in_accept;
    logic [VAL_W-1:0] result;

    assign o_in_ready = q_ready;
    assign in_accept  = i_in_valid && q_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_SUM;
            r_relu  <= 1'b0;
            r_shift <= '0;
            for (int i = 0; i < NUM_MULT; i++) begin
                r_mult[i] <= VAL_W'(1);
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_COMBINE_MODE: r_mode    <= i_cfg_data[1:0];
                CFG_RELU_ENABLE:  r_relu    <= i_cfg_data[0];
                CFG_SHIFT_AMOUNT: r_shift   <= i_cfg_data[SHF_W-1:0];
                CFG_MULT_0:       r_mult[0] <= i_cfg_data;
                CFG_MULT_1:       r_mult[1] <= i_cfg_data;
                CFG_MULT_2:       r_mult[2] <= i_cfg_data;
                CFG_MULT_3:       r_mult[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    i8ew_front #(
        .MAX_OPERANDS (MAX_OPERANDS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (q_ready),
        .i_operand_value (i_operand_value),
        .i_last_operand  (i_last_operand),
        .i_mode          (r_mode),
        .i_relu          (r_relu),
        .i_shift         (r_shift),
        .i_mult          (r_mult),
        .o_entry         (front_entry)
    );

    i8ew_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_entry (front_entry),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_entry (back_entry)
    );

    i8ew_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (q_valid),
        .i_entry        (back_entry),
        .o_pop          (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_result_value (result)
    );

    assign o_result_value = $signed(result);

endmodule
